>>> rtl/tbpf_pkg.sv
// Shared constants and a helper function of the background pixel fetch block.
`default_nettype none

package tbpf_pkg;

   // Video memory layout: tile data below the maps, two 1 KiB tile maps on top.
   localparam int VRAM_ADDR_WIDTH = 13;
   localparam int MAP_DEPTH       = 2048;
   localparam int MAP_ADDR_WIDTH  = $clog2(MAP_DEPTH);
   localparam int DATA_DEPTH      = 3072;   // bank entries per bit plane byte
   localparam int DATA_ADDR_WIDTH = $clog2(DATA_DEPTH);

   // Field widths.
   localparam int COORD_WIDTH = 8;
   localparam int BYTE_WIDTH  = 8;
   localparam int SHADE_WIDTH = 2;
   localparam int RGB_WIDTH   = 24;

   // Stream payload sizes, rounded up to whole bytes.
   localparam int REQ_FIELDS_WIDTH = VRAM_ADDR_WIDTH + BYTE_WIDTH + 2 * COORD_WIDTH;
   localparam int REQ_DATA_WIDTH   = ((REQ_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_WIDTH = 2 * COORD_WIDTH + SHADE_WIDTH + RGB_WIDTH;
   localparam int RSP_DATA_WIDTH   = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   // Operation codes carried in tuser.
   localparam logic OP_VRAM_WRITE = 1'b0;
   localparam logic OP_PIXEL      = 1'b1;

   // Register indexes.
   localparam int CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCROLL_X    = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SCROLL_Y    = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LCD_CONTROL = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BG_PALETTE  = 8'd3;

   // Register reset values.
   localparam logic [BYTE_WIDTH-1:0] LCD_CONTROL_RESET = 8'h91;
   localparam logic [BYTE_WIDTH-1:0] BG_PALETTE_RESET  = 8'hFC;

   // Control register bit positions.
   localparam int LCD_BG_ON    = 0;
   localparam int LCD_MAP_SEL  = 3;
   localparam int LCD_DATA_SEL = 4;

   // Four-green shade table.
   function automatic logic [RGB_WIDTH-1:0] shade_rgb_of(input logic [SHADE_WIDTH-1:0] shade);
      logic [RGB_WIDTH-1:0] rgb;
      case (shade)
         2'd0:    rgb = 24'h9BBC0F;
         2'd1:    rgb = 24'h8BAC0F;
         2'd2:    rgb = 24'h306230;
         2'd3:    rgb = 24'h0F380F;
         default: rgb = 24'h9BBC0F;
      endcase
      return rgb;
   endfunction

endpackage

`default_nettype wire

>>> rtl/tbpf_ram.sv
// Generic single-write, single-read RAM with a registered, read-first read port.
`default_nettype none

module tbpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/tile_background_pixel_fetch.sv
// Top level of the background tile pixel fetch block.
`default_nettype none

// The block keeps the 8 KiB video memory of a tile-based background and turns
// pixel requests into palette-mapped shades. One item moves per clock on the
// request stream while the pipeline is not stalled: a video memory byte write
// or a pixel request, selected by req_tuser. Every pixel request gives exactly
// one result transfer, passing through stage one, stage two and the output
// register; writes give none. The rate of one pixel per clock, when the result
// side does not stall, is set by two dependent memory reads in a pipeline: the
// tile map lives in its own 2 KiB memory and the tile data in two banks holding
// the even and odd bit-plane bytes, so the map lookup of one pixel and the
// bit-plane fetch of the one before it proceed in the same cycle. After reset
// the block runs a clearing pass that zeros the memories; req_tready stays low
// during it, while register writes on the csr_ port are taken at any time.
// Registers should only be written while no pixel is in flight.
module tile_background_pixel_fetch
   import tbpf_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   // Request stream.
   input  wire logic                       req_tvalid,
   output      logic                       req_tready,
   // tdata, from bit 0 up: vram_addr[12:0], vram_data[7:0], pixel_x[7:0],
   // pixel_y[7:0], zero fill.
   input  wire logic [REQ_DATA_WIDTH-1:0]  req_tdata,
   // tuser: op (0 video memory write, 1 pixel request).
   input  wire logic                       req_tuser,

   // Result stream.
   output      logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   // tdata, from bit 0 up: out_x[7:0], out_y[7:0], color_index[1:0],
   // shade_rgb[23:0], zero fill.
   output      logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,

   // Register write channel.
   input  wire logic                       csr_valid,
   output      logic                       csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [BYTE_WIDTH-1:0]      csr_data
);

   // Registers.
   logic [BYTE_WIDTH-1:0] scroll_x_ff;
   logic [BYTE_WIDTH-1:0] scroll_y_ff;
   logic [BYTE_WIDTH-1:0] lcd_control_ff;
   logic [BYTE_WIDTH-1:0] bg_palette_ff;

   // Clearing pass.
   logic                       clearing_ff;
   logic [DATA_ADDR_WIDTH-1:0] clear_count_ff;

   // Request fields.
   logic                       req_accept;
   logic                       req_op;
   logic [VRAM_ADDR_WIDTH-1:0] req_vram_addr;
   logic [BYTE_WIDTH-1:0]      req_vram_data;
   logic [COORD_WIDTH-1:0]     req_pixel_x;
   logic [COORD_WIDTH-1:0]     req_pixel_y;

   // Pipeline control.
   logic enable_s1;
   logic enable_s2;
   logic enable_out;

   // Stage one: tile index coming out of the map memory.
   logic                   s1_valid_ff;
   logic [2:0]             s1_fine_x_ff;
   logic [2:0]             s1_fine_y_ff;
   logic [COORD_WIDTH-1:0] s1_x_ff;
   logic [COORD_WIDTH-1:0] s1_y_ff;

   // Stage two: bit-plane bytes coming out of the data banks.
   logic                   s2_valid_ff;
   logic [2:0]             s2_fine_x_ff;
   logic [COORD_WIDTH-1:0] s2_x_ff;
   logic [COORD_WIDTH-1:0] s2_y_ff;

   // Output register.
   logic                   out_valid_ff;
   logic [COORD_WIDTH-1:0] out_x_ff;
   logic [COORD_WIDTH-1:0] out_y_ff;
   logic [SHADE_WIDTH-1:0] out_shade_ff;
   logic [RGB_WIDTH-1:0]   out_rgb_ff;

   // Memory ports.
   logic                       map_wr_en;
   logic [MAP_ADDR_WIDTH-1:0]  map_wr_addr;
   logic [BYTE_WIDTH-1:0]      map_wr_data;
   logic [MAP_ADDR_WIDTH-1:0]  map_rd_addr;
   logic [BYTE_WIDTH-1:0]      map_rd_data;
   logic                       even_wr_en;
   logic                       odd_wr_en;
   logic [DATA_ADDR_WIDTH-1:0] data_wr_addr;
   logic [BYTE_WIDTH-1:0]      data_wr_data;
   logic [DATA_ADDR_WIDTH-1:0] data_rd_addr;
   logic [BYTE_WIDTH-1:0]      plane_lo;
   logic [BYTE_WIDTH-1:0]      plane_hi;

   // Pixel math.
   logic [COORD_WIDTH-1:0] bg_x;
   logic [COORD_WIDTH-1:0] bg_y;
   logic                   write_to_map;
   logic                   vram_write;
   logic [2:0]             bit_sel;
   logic [1:0]             color_raw;
   logic [SHADE_WIDTH-1:0] shade_in;

   // The register port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_x_ff    <= '0;
         scroll_y_ff    <= '0;
         lcd_control_ff <= LCD_CONTROL_RESET;
         bg_palette_ff  <= BG_PALETTE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCROLL_X:    scroll_x_ff    <= csr_data;
            CSR_SCROLL_Y:    scroll_y_ff    <= csr_data;
            CSR_LCD_CONTROL: lcd_control_ff <= csr_data;
            CSR_BG_PALETTE:  bg_palette_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // The clearing pass walks the data banks; the smaller map memory is
   // covered by the low part of the same count.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff    <= 1'b1;
         clear_count_ff <= '0;
      end else if (clearing_ff) begin
         clear_count_ff <= clear_count_ff + 1'b1;
         if (clear_count_ff == DATA_ADDR_WIDTH'(DATA_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   assign req_op        = req_tuser;
   assign req_vram_addr = req_tdata[VRAM_ADDR_WIDTH-1:0];
   assign req_vram_data = req_tdata[VRAM_ADDR_WIDTH +: BYTE_WIDTH];
   assign req_pixel_x   = req_tdata[VRAM_ADDR_WIDTH + BYTE_WIDTH +: COORD_WIDTH];
   assign req_pixel_y   = req_tdata[VRAM_ADDR_WIDTH + BYTE_WIDTH + COORD_WIDTH +: COORD_WIDTH];

   // Each stage moves forward when the stage after it is empty or moving too.
   assign enable_out = !out_valid_ff || rsp_tready;
   assign enable_s2  = !s2_valid_ff || enable_out;
   assign enable_s1  = !s1_valid_ff || enable_s2;
   assign req_tready = enable_s1 && !clearing_ff;
   assign req_accept = req_tvalid && req_tready;

   // Byte writes land in the map memory from offset 0x1800 up and in the
   // even or odd data bank below it.
   assign write_to_map = (req_vram_addr[VRAM_ADDR_WIDTH-1 -: 2] == 2'b11);
   assign vram_write   = req_accept && (req_op == OP_VRAM_WRITE);

   always_comb begin
      if (clearing_ff) begin
         map_wr_en    = 1'b1;
         map_wr_addr  = clear_count_ff[MAP_ADDR_WIDTH-1:0];
         map_wr_data  = '0;
         even_wr_en   = 1'b1;
         odd_wr_en    = 1'b1;
         data_wr_addr = clear_count_ff;
         data_wr_data = '0;
      end else begin
         map_wr_en    = vram_write && write_to_map;
         map_wr_addr  = req_vram_addr[MAP_ADDR_WIDTH-1:0];
         map_wr_data  = req_vram_data;
         even_wr_en   = vram_write && !write_to_map && !req_vram_addr[0];
         odd_wr_en    = vram_write && !write_to_map && req_vram_addr[0];
         data_wr_addr = req_vram_addr[VRAM_ADDR_WIDTH-1:1];
         data_wr_data = req_vram_data;
      end
   end

   // Map lookup: scrolled position wraps at 256, one byte per 8x8 tile.
   assign bg_x        = req_pixel_x + scroll_x_ff;
   assign bg_y        = req_pixel_y + scroll_y_ff;
   assign map_rd_addr = {lcd_control_ff[LCD_MAP_SEL], bg_y[7:3], bg_x[7:3]};

   tbpf_ram #(
      .WIDTH (BYTE_WIDTH),
      .DEPTH (MAP_DEPTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_en   (enable_s1),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable_s1) begin
         s1_valid_ff <= req_accept && (req_op == OP_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (enable_s1) begin
         s1_fine_x_ff <= bg_x[2:0];
         s1_fine_y_ff <= bg_y[2:0];
         s1_x_ff      <= req_pixel_x;
         s1_y_ff      <= req_pixel_y;
      end
   end

   // Row address in 16-bit words. In the signed mode, indexes 0 to 127 sit
   // above offset 0x1000 and indexes 128 to 255 below it, so only the top
   // bit differs from the unsigned mode.
   assign data_rd_addr = {!map_rd_data[7] && !lcd_control_ff[LCD_DATA_SEL],
                          map_rd_data, s1_fine_y_ff};

   tbpf_ram #(
      .WIDTH (BYTE_WIDTH),
      .DEPTH (DATA_DEPTH)
   ) u_even_ram (
      .clock   (clock),
      .wr_en   (even_wr_en),
      .wr_addr (data_wr_addr),
      .wr_data (data_wr_data),
      .rd_en   (enable_s2),
      .rd_addr (data_rd_addr),
      .rd_data (plane_lo)
   );

   tbpf_ram #(
      .WIDTH (BYTE_WIDTH),
      .DEPTH (DATA_DEPTH)
   ) u_odd_ram (
      .clock   (clock),
      .wr_en   (odd_wr_en),
      .wr_addr (data_wr_addr),
      .wr_data (data_wr_data),
      .rd_en   (enable_s2),
      .rd_addr (data_rd_addr),
      .rd_data (plane_hi)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable_s2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable_s2) begin
         s2_fine_x_ff <= s1_fine_x_ff;
         s2_x_ff      <= s1_x_ff;
         s2_y_ff      <= s1_y_ff;
      end
   end

   // The leftmost pixel of a tile row is the most significant bit.
   assign bit_sel   = ~s2_fine_x_ff;
   assign color_raw = {plane_hi[bit_sel], plane_lo[bit_sel]};
   assign shade_in  = lcd_control_ff[LCD_BG_ON] ? bg_palette_ff[{color_raw, 1'b0} +: SHADE_WIDTH]
                                                 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable_out) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable_out) begin
         out_x_ff     <= s2_x_ff;
         out_y_ff     <= s2_y_ff;
         out_shade_ff <= shade_in;
         out_rgb_ff   <= shade_rgb_of(shade_in);
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_WIDTH - RSP_FIELDS_WIDTH)'(0),
                        out_rgb_ff, out_shade_ff, out_y_ff, out_x_ff};

endmodule

`default_nettype wire

>>> rtl/tbpf_checker.sv
// Port-level checker for the background pixel fetch block, bound to its top level.
`default_nettype none

module tbpf_checker
   import tbpf_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_tready,
   input wire logic                      rsp_tvalid,
   input wire logic                      rsp_tready,
   input wire logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // A stalled result transfer keeps its valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result valid dropped while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // Reset empties the pipeline and starts the memory clearing pass.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block not idle and clearing after reset");

   // The RGB value always matches the shade index it travels with.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2*COORD_WIDTH+SHADE_WIDTH +: RGB_WIDTH] ==
                     shade_rgb_of(rsp_tdata[2*COORD_WIDTH +: SHADE_WIDTH]))
      else $error("shade RGB does not match shade index");

endmodule

bind tile_background_pixel_fetch tbpf_checker u_tbpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> tb/sv/tile_background_pixel_fetch_test.sv
// Self-checking testbench for the background tile pixel fetch block.
`timescale 1ns / 100ps

module tile_background_pixel_fetch_test;
   import tbpf_pkg::*;

   // The clock runs with a 20 ns period.
   localparam int HALF_PERIOD = 10;

   // The slowest correct run is roughly 1800 items with both sides stalling,
   // plus the clearing pass after reset, the long receiver hold-off and a short
   // settle per register setting, so this limit leaves a wide margin.
   localparam int CYCLE_LIMIT = 500000;

   // The pipeline is three stages deep. Writes give no result, so after the
   // last expected result a write may still be on its way into the memory.
   localparam int SETTLE_CYCLES = 8;

   // The receiver holds off for this many cycles once, in the last phase.
   localparam int HOLD_OFF_CYCLES = 300;

   // The random part is three idling phases of several register settings each.
   localparam int PHASE_COUNT       = 3;
   localparam int BLOCKS_PER_PHASE  = 6;
   localparam int ITEMS_PER_BLOCK   = 97;
   localparam int PHASE_SEND_IDLE [PHASE_COUNT] = '{21, 67, 0};
   localparam int PHASE_RECV_IDLE [PHASE_COUNT] = '{67, 21, 0};

   // Video memory layout as seen by the renderer.
   localparam logic [12:0] MAP_LOW_BASE     = 13'h1800;
   localparam logic [12:0] MAP_HIGH_BASE    = 13'h1C00;
   localparam logic [12:0] MAP_BYTES        = 13'h0800;
   localparam logic [15:0] SIGNED_DATA_BASE = 16'h1000;
   localparam logic [12:0] TILE_DATA_TOP    = 13'h17FF;

   // Writes to this register index land nowhere.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_INDEX = 8'hFF;

   // The four greens, from lightest to darkest shade.
   localparam logic [RGB_WIDTH-1:0] GREEN_SHADES [4] =
      '{24'h9BBC0F, 24'h8BAC0F, 24'h306230, 24'h0F380F};

   // Tile numbers that the random writes favor, so that map entries and the
   // tile rows they point to meet often. Both ends of the signed range are in.
   localparam logic [7:0] FAVORED_TILES [8] =
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h7F, 8'h80, 8'h81, 8'hFF};

   typedef struct {
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
      logic [SHADE_WIDTH-1:0] shade;
      logic [RGB_WIDTH-1:0]   rgb;
   } pixel_result_type;

   typedef enum logic [1:0] {
      ROW_VRAM_WRITE,
      ROW_PIXEL,
      ROW_CSR
   } row_kind_type;

   // One line of the directed stimulus. A register row carries its index in
   // addr. Where fixed is set, the result is typed in rather than predicted.
   typedef struct packed {
      row_kind_type           kind;
      logic [12:0]            addr;
      logic [7:0]             data;
      logic [COORD_WIDTH-1:0] px;
      logic [COORD_WIDTH-1:0] py;
      logic                   fixed;
      logic [SHADE_WIDTH-1:0] shade;
      logic [RGB_WIDTH-1:0]   rgb;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 27;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // Right after reset the memory is clear and the background is on, so
      // every pixel is color 0, which the reset palette maps to shade 0.
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd0,   8'd0,   1'b1, 2'd0, 24'h9BBC0F},
      // Last on-screen pixel; the write fields carry all ones and are ignored.
      '{ROW_PIXEL,      13'h1FFF, 8'hFF, 8'd159, 8'd143, 1'b1, 2'd0, 24'h9BBC0F},
      // A pixel beyond the screen is rendered like any other coordinate.
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd255, 8'd255, 1'b1, 2'd0, 24'h9BBC0F},
      // Map entry (0,0) of the low map points to tile 1; the coordinates of a
      // write are ignored. Then rows 0 and 1 of tile 1 get both bit planes.
      '{ROW_VRAM_WRITE, 13'h1800, 8'h01, 8'd255, 8'd255, 1'b0, 2'd0, 24'h0},
      '{ROW_VRAM_WRITE, 13'h0010, 8'h80, 8'd0,   8'd0,   1'b0, 2'd0, 24'h0},
      '{ROW_VRAM_WRITE, 13'h0011, 8'h40, 8'd0,   8'd0,   1'b0, 2'd0, 24'h0},
      '{ROW_VRAM_WRITE, 13'h0012, 8'hFF, 8'd0,   8'd0,   1'b0, 2'd0, 24'h0},
      '{ROW_VRAM_WRITE, 13'h0013, 8'hFF, 8'd0,   8'd0,   1'b0, 2'd0, 24'h0},
      // Colors 1, 2 and 3 through the reset palette.
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd0,   8'd0,   1'b0, 2'd0, 24'h0},
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd1,   8'd0,   1'b0, 2'd0, 24'h0},
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd7,   8'd1,   1'b0, 2'd0, 24'h0},
      // Identity palette.
      '{ROW_CSR,        13'(CSR_BG_PALETTE), 8'hE4, 8'd0, 8'd0, 1'b0, 2'd0, 24'h0},
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd1,   8'd0,   1'b0, 2'd0, 24'h0},
      // Both scroll offsets at their top value wrap the background around.
      '{ROW_CSR,        13'(CSR_SCROLL_X), 8'hFF, 8'd0, 8'd0, 1'b0, 2'd0, 24'h0},
      '{ROW_CSR,        13'(CSR_SCROLL_Y), 8'hFF, 8'd0, 8'd0, 1'b0, 2'd0, 24'h0},
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd1,   8'd2,   1'b0, 2'd0, 24'h0},
      // High map and signed tile numbers: tile 0x80 sits 2 KiB below the
      // signed base.
      '{ROW_CSR,        13'(CSR_LCD_CONTROL), 8'h09, 8'd0, 8'd0, 1'b0, 2'd0, 24'h0},
      '{ROW_VRAM_WRITE, 13'h1C00, 8'h80, 8'd0,   8'd0,   1'b0, 2'd0, 24'h0},
      '{ROW_VRAM_WRITE, 13'h0802, 8'hFF, 8'd0,   8'd0,   1'b0, 2'd0, 24'h0},
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd1,   8'd2,   1'b0, 2'd0, 24'h0},
      // A write to a register index that does not exist changes nothing.
      '{ROW_CSR,        13'(CSR_UNMAPPED_INDEX), 8'h00, 8'd0, 8'd0, 1'b0, 2'd0, 24'h0},
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd8,   8'd2,   1'b0, 2'd0, 24'h0},
      // Top memory address, which is the last entry of the high map.
      '{ROW_VRAM_WRITE, 13'h1FFF, 8'h00, 8'd0,   8'd0,   1'b0, 2'd0, 24'h0},
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd255, 8'd0,   1'b0, 2'd0, 24'h0},
      // Background off: color 0 and shade 0 whatever the palette says.
      '{ROW_CSR,        13'(CSR_LCD_CONTROL), 8'h00, 8'd0, 8'd0, 1'b0, 2'd0, 24'h0},
      '{ROW_PIXEL,      13'h0000, 8'h00, 8'd0,   8'd0,   1'b1, 2'd0, 24'h9BBC0F},
      '{ROW_VRAM_WRITE, 13'h0000, 8'hFF, 8'd0,   8'd0,   1'b0, 2'd0, 24'h0}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                       req_tuser = OP_VRAM_WRITE;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [BYTE_WIDTH-1:0]      csr_data = '0;

   // Our own picture of the block: video memory and the four registers.
   logic [7:0] vram_image [8192];
   logic [7:0] bg_scroll_x  = 8'h00;
   logic [7:0] bg_scroll_y  = 8'h00;
   logic [7:0] bg_control   = LCD_CONTROL_RESET;
   logic [7:0] bg_shade_map = BG_PALETTE_RESET;

   // Pixels that have been requested and whose result transfer is still due.
   pixel_result_type pending_pixels [$];

   int  send_idle_pct     = PHASE_SEND_IDLE[0];
   int  recv_idle_pct     = PHASE_RECV_IDLE[0];
   bit  hold_off_request  = 1'b0;
   int  hold_off_left     = 0;
   int  cycle_count       = 0;
   int  error_count       = 0;
   int  write_count       = 0;
   int  pixel_count       = 0;
   int  result_count      = 0;
   int  setting_count     = 0;

   tile_background_pixel_fetch dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Where the rows of a tile start, for either tile data mode. In signed mode
   // the tile number counts from the signed base, wrapping within 64 KiB, and
   // only the low 13 bits reach the memory.
   function automatic logic [12:0] tile_base(input logic [7:0] tile, input logic unsigned_mode);
      logic [15:0] offset;
      if (unsigned_mode) begin
         offset = {4'h0, tile, 4'h0};
      end else begin
         offset = SIGNED_DATA_BASE + {{4{tile[7]}}, tile, 4'h0};
      end
      return offset[12:0];
   endfunction

   // Works out the result of one pixel request from the current picture.
   function automatic pixel_result_type render_pixel(input logic [7:0] px, input logic [7:0] py);
      pixel_result_type result;
      logic [7:0]    bx;
      logic [7:0]    by;
      logic [12:0]   map_addr;
      logic [12:0]   row_addr;
      logic [7:0]    plane_lo;
      logic [7:0]    plane_hi;
      logic [2:0]    bit_pos;
      logic [1:0]    color;
      result.x     = px;
      result.y     = py;
      result.shade = 2'd0;
      if (bg_control[LCD_BG_ON]) begin
         bx       = px + bg_scroll_x;
         by       = py + bg_scroll_y;
         map_addr = (bg_control[LCD_MAP_SEL] ? MAP_HIGH_BASE : MAP_LOW_BASE)
                    + {3'b000, by[7:3], bx[7:3]};
         row_addr = tile_base(vram_image[map_addr], bg_control[LCD_DATA_SEL])
                    + {9'd0, by[2:0], 1'b0};
         plane_lo = vram_image[row_addr];
         plane_hi = vram_image[row_addr + 13'd1];
         // The leftmost pixel of a row is the top bit of each plane.
         bit_pos      = 3'd7 - bx[2:0];
         color        = {plane_hi[bit_pos], plane_lo[bit_pos]};
         result.shade = bg_shade_map[2 * color +: 2];
      end
      result.rgb = GREEN_SHADES[result.shade];
      return result;
   endfunction

   // Offers one item on the request stream and books it once it is taken.
   // Called and left at a falling edge; valid stays high into the next item
   // unless that item starts with an idle gap.
   task automatic send_item(input logic op, input logic [12:0] addr, input logic [7:0] data,
                            input logic [7:0] px, input logic [7:0] py,
                            input logic fixed, input pixel_result_type fixed_result);
      bit taken;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {3'b000, py, px, data, addr};
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_tready;
      end
      if (op == OP_VRAM_WRITE) begin
         vram_image[addr] = data;
         write_count++;
      end else begin
         pending_pixels.push_back(fixed ? fixed_result : render_pixel(px, py));
         pixel_count++;
      end
      @(negedge clock);
   endtask

   // Waits until every result is in and the pipeline has drained of writes.
   task automatic wait_idle();
      req_tvalid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [7:0] value);
      bit taken;
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = value;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = csr_ready;
      end
      case (index)
         CSR_SCROLL_X:    bg_scroll_x  = value;
         CSR_SCROLL_Y:    bg_scroll_y  = value;
         CSR_LCD_CONTROL: bg_control   = value;
         CSR_BG_PALETTE:  bg_shade_map = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // A register value that hits both ends of the range now and then.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Draws a new register setting once the block has gone quiet. The
   // background is mostly left on so that the tile lookup gets exercised.
   task automatic apply_random_setting();
      logic [7:0] control;
      wait_idle();
      control = pick_byte();
      if ($urandom_range(0, 4) != 0) control[LCD_BG_ON] = 1'b1;
      write_register(CSR_SCROLL_X, pick_byte());
      write_register(CSR_SCROLL_Y, pick_byte());
      write_register(CSR_LCD_CONTROL, control);
      write_register(CSR_BG_PALETTE, pick_byte());
      if ($urandom_range(0, 3) == 0) begin
         write_register(8'($urandom_range(4, 255)), 8'($urandom_range(0, 255)));
      end
      setting_count++;
   endtask

   // Random items are built so that tile map entries and the tile rows they
   // name are written often, with some writes scattered over all of memory.
   // Each item carries random noise in the fields it does not use.
   task automatic send_random_item();
      logic [12:0]   addr;
      logic [7:0]    data;
      logic [7:0]    px;
      logic [7:0]    py;
      pixel_result_type unused;
      addr = 13'($urandom_range(0, 8191));
      data = 8'($urandom_range(0, 255));
      px   = 8'($urandom_range(0, 255));
      py   = 8'($urandom_range(0, 255));
      unused = '{default: '0};
      if ($urandom_range(0, 99) < 45) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               addr = MAP_LOW_BASE + 13'($urandom_range(0, MAP_BYTES - 1));
               if ($urandom_range(0, 3) != 0) data = FAVORED_TILES[$urandom_range(0, 7)];
            end
            4, 5, 6, 7: begin
               addr = tile_base(FAVORED_TILES[$urandom_range(0, 7)], 1'($urandom_range(0, 1)))
                      + 13'($urandom_range(0, 15));
            end
            8: addr = 13'($urandom_range(0, TILE_DATA_TOP));
            default: ;
         endcase
         send_item(OP_VRAM_WRITE, addr, data, px, py, 1'b0, unused);
      end else begin
         px = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(160, 255))
                                          : 8'($urandom_range(0, 159));
         py = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(144, 255))
                                          : 8'($urandom_range(0, 143));
         send_item(OP_PIXEL, addr, data, px, py, 1'b0, unused);
      end
   endtask

   task automatic check_field(input string name, input logic [23:0] want, input logic [23:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // The receiver stalls at the rate of the current phase. When asked, it
   // holds off for a long stretch instead, so the block backs up and stops
   // taking requests.
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_tready = 1'b0;
         hold_off_left--;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_off_left    = HOLD_OFF_CYCLES;
         rsp_tready       = 1'b0;
      end else begin
         rsp_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Every result transfer is matched against the oldest pending pixel.
   always @(posedge clock) begin : result_check
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t ns: result transfer with no pixel pending, tdata 0x%0h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("out_x", 24'(want.x), 24'(rsp_tdata[7:0]));
            check_field("out_y", 24'(want.y), 24'(rsp_tdata[15:8]));
            check_field("color_index", 24'(want.shade), 24'(rsp_tdata[17:16]));
            check_field("shade_rgb", want.rgb, rsp_tdata[41:18]);
            result_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_pixels.size());
         $display("tile_background_pixel_fetch_test failed");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      pixel_result_type typed;
      foreach (vram_image[i]) vram_image[i] = 8'h00;

      // Synchronous reset at the start; the block then clears its
      // memories, which the request handshake simply waits out.
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed part, run with the idling of the first phase.
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = DIRECTED_ROWS[i];
         typed = '{x: row.px, y: row.py, shade: row.shade, rgb: row.rgb};
         case (row.kind)
            ROW_CSR: begin
               wait_idle();
               write_register(row.addr[CSR_INDEX_WIDTH-1:0], row.data);
            end
            ROW_VRAM_WRITE:
               send_item(OP_VRAM_WRITE, row.addr, row.data, row.px, row.py, 1'b0, typed);
            default:
               send_item(OP_PIXEL, row.addr, row.data, row.px, row.py, row.fixed, typed);
         endcase
      end

      // Random part: a fresh register setting for every block of items.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         send_idle_pct = PHASE_SEND_IDLE[p];
         recv_idle_pct = PHASE_RECV_IDLE[p];
         for (int b = 0; b < BLOCKS_PER_PHASE; b++) begin
            apply_random_setting();
            // With neither side idling, one long receiver stall backs the
            // block up against a sender that keeps offering items.
            if (p == PHASE_COUNT - 1 && b == 0) hold_off_request = 1'b1;
            repeat (ITEMS_PER_BLOCK) send_random_item();
         end
      end

      wait_idle();
      $display("Sent %0d video memory writes and %0d pixel requests over %0d register settings;",
               write_count, pixel_count, setting_count);
      $display("checked %0d results, %0d mismatches, in %0d cycles.",
               result_count, error_count, cycle_count);
      if (error_count == 0) begin
         $display("tile_background_pixel_fetch_test passed");
      end else begin
         $display("tile_background_pixel_fetch_test failed");
      end
      $finish;
   end

endmodule
